[rtl/kvf_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kvf_pkg
// Shared constants and types for the key-value get request filter.
// ----------------------------------------------------------------------------
package kvf_pkg;

	// configuration register indexes
	localparam logic [7:0] REG_SERVICE_PORT   = 8'd0;
	localparam logic [7:0] REG_VALUE_LEN_ZERO = 8'd1;
	localparam logic [7:0] REG_VALUE_LEN_ONE  = 8'd2;
	localparam logic [7:0] REG_MAX_RESP_LEN   = 8'd3;

	localparam logic [15:0] SERVICE_PORT_RST   = 16'd11211;
	localparam logic [13:0] VALUE_LEN_ZERO_RST = 14'd1100;
	localparam logic [13:0] VALUE_LEN_ONE_RST  = 14'd1000;
	localparam logic [15:0] MAX_RESP_LEN_RST   = 16'd1500;

	// byte positions inside the request frame
	localparam logic [15:0] POS_ETHERTYPE = 16'd13;
	localparam logic [15:0] POS_IHL       = 16'd14;
	localparam logic [15:0] POS_PROTOCOL  = 16'd23;
	localparam logic [15:0] POS_SRC_FIRST = 16'd26;
	localparam logic [15:0] POS_SRC_LAST  = 16'd29;
	localparam logic [15:0] POS_DST_FIRST = 16'd30;
	localparam logic [15:0] POS_DST_LAST  = 16'd33;
	localparam logic [15:0] POS_UDP_DPORT = 16'd37;
	localparam logic [15:0] POS_DGRAM_CNT = 16'd47;
	localparam logic [15:0] POS_CMD_G     = 16'd50;
	localparam logic [15:0] POS_CMD_E     = 16'd51;
	localparam logic [15:0] POS_CMD_T     = 16'd52;
	localparam logic [15:0] POS_CMD_SP    = 16'd53;
	localparam logic [15:0] KEY_START     = 16'd54;
	localparam logic [15:0] POS_MAX       = 16'hFFFF;

	localparam logic [15:0] ETHERTYPE_IPV4 = 16'h0800;
	localparam logic [3:0]  IHL_PLAIN      = 4'd5;
	localparam logic [7:0]  PROTO_UDP      = 8'd17;
	localparam logic [15:0] DGRAM_COUNT    = 16'd1;

	localparam logic [7:0] CHAR_G     = 8'h67;
	localparam logic [7:0] CHAR_E     = 8'h65;
	localparam logic [7:0] CHAR_T     = 8'h74;
	localparam logic [7:0] CHAR_SPACE = 8'h20;
	localparam logic [7:0] CHAR_CR    = 8'h0D;
	localparam logic [7:0] CHAR_TAB   = 8'h09;
	localparam logic [7:0] CHAR_FF    = 8'h0C;
	localparam logic [7:0] CHAR_PLUS  = 8'h2B;
	localparam logic [7:0] CHAR_MINUS = 8'h2D;
	localparam logic [7:0] CHAR_ZERO  = 8'h30;
	localparam logic [7:0] CHAR_NINE  = 8'h39;

	localparam logic [7:0] MAX_KEY_BYTES = 8'd255;

	// key number class
	localparam logic [1:0] CLASS_NONE  = 2'd0;
	localparam logic [1:0] CLASS_ZERO  = 2'd1;
	localparam logic [1:0] CLASS_ONE   = 2'd2;
	localparam logic [1:0] CLASS_OTHER = 2'd3;

	// key sign phase
	localparam logic [1:0] PHASE_START = 2'd0;
	localparam logic [1:0] PHASE_POS   = 2'd1;
	localparam logic [1:0] PHASE_NEG   = 2'd2;
	localparam logic [1:0] PHASE_DONE  = 2'd3;

	// response length offsets
	localparam logic [15:0] PAYLOAD_BASE  = 16'd14;
	localparam logic [15:0] IP_TOTAL_BASE = 16'd36;
	localparam logic [15:0] UDP_BASE      = 16'd16;
	localparam logic [15:0] RESP_BASE     = 16'd50;

	// fixed words of the response IPv4 header: version/ihl, ttl/protocol
	localparam logic [19:0] HDR_FIXED_SUM = 20'h04500 + 20'h04011;

	// what the frame tracker hands over at the end of a frame
	typedef struct packed {
		logic        hdr_ok;
		logic [1:0]  key_class;
		logic [7:0]  key_count;
		logic [31:0] src_addr;
		logic [31:0] dst_addr;
	} frame_sum_t;

endpackage : kvf_pkg
`default_nettype wire

[rtl/kvf_frame_track.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kvf_frame_track
// Per-byte header checks, address capture and key parsing of a request frame.
// ----------------------------------------------------------------------------
module kvf_frame_track
	import kvf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        take,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_end,
	input  wire logic [15:0] service_port,
	output frame_sum_t       frame_sum
);

	logic [15:0] pos_q, pos_n;
	logic        hv_q, hv_n;
	logic [31:0] src_q, src_n;
	logic [31:0] dst_q, dst_n;
	logic [15:0] shift_q, shift_n;
	logic [7:0]  count_q, count_n;
	logic        closed_q, closed_n;
	logic [1:0]  class_q, class_n;
	logic [1:0]  phase_q, phase_n;

	logic       in_key;
	logic       is_digit;
	logic       small_mag;
	logic [3:0] digit_val;
	logic [1:0] phase_d;

	always_comb begin
		shift_n   = {shift_q[7:0], data_byte};
		hv_n      = hv_q;
		src_n     = src_q;
		dst_n     = dst_q;
		count_n   = count_q;
		closed_n  = closed_q;
		class_n   = class_q;
		phase_n   = phase_q;
		is_digit  = (data_byte >= CHAR_ZERO) && (data_byte <= CHAR_NINE);
		digit_val = 4'(data_byte - CHAR_ZERO);
		small_mag = (class_q == CLASS_NONE) || (class_q == CLASS_ZERO);
		phase_d   = (phase_q == PHASE_START) ? PHASE_POS : phase_q;
		in_key    = (pos_q >= KEY_START) && !closed_q;

		case (pos_q)
			POS_ETHERTYPE: begin
				if (shift_n != ETHERTYPE_IPV4) hv_n = 1'b0;
			end
			POS_IHL: begin
				if (data_byte[3:0] != IHL_PLAIN) hv_n = 1'b0;
			end
			POS_PROTOCOL: begin
				if (data_byte != PROTO_UDP) hv_n = 1'b0;
			end
			POS_UDP_DPORT: begin
				if (shift_n != service_port) hv_n = 1'b0;
			end
			POS_DGRAM_CNT: begin
				if (shift_n != DGRAM_COUNT) hv_n = 1'b0;
			end
			POS_CMD_G: begin
				if (data_byte != CHAR_G) hv_n = 1'b0;
			end
			POS_CMD_E: begin
				if (data_byte != CHAR_E) hv_n = 1'b0;
			end
			POS_CMD_T: begin
				if (data_byte != CHAR_T) hv_n = 1'b0;
			end
			POS_CMD_SP: begin
				if (data_byte != CHAR_SPACE) hv_n = 1'b0;
			end
			default: begin
			end
		endcase

		if (pos_q >= POS_SRC_FIRST && pos_q <= POS_SRC_LAST) begin
			src_n = {src_q[23:0], data_byte};
		end else if (pos_q >= POS_DST_FIRST && pos_q <= POS_DST_LAST) begin
			dst_n = {dst_q[23:0], data_byte};
		end

		if (in_key) begin
			if (count_q >= MAX_KEY_BYTES || data_byte == CHAR_SPACE || data_byte == CHAR_CR) begin
				closed_n = 1'b1;
			end else begin
				count_n = count_q + 8'd1;
				// leading number of the key: only 0 or 1 is served
				if (phase_q != PHASE_DONE) begin
					if (is_digit) begin
						phase_n = phase_d;
						if (small_mag && digit_val == 4'd0) begin
							class_n = CLASS_ZERO;
						end else if (small_mag && digit_val == 4'd1 && phase_d == PHASE_POS) begin
							class_n = CLASS_ONE;
						end else begin
							class_n = CLASS_OTHER;
						end
					end else if (phase_q == PHASE_START) begin
						if (data_byte >= CHAR_TAB && data_byte <= CHAR_FF) begin
							phase_n = phase_q;
						end else if (data_byte == CHAR_PLUS) begin
							phase_n = PHASE_POS;
						end else if (data_byte == CHAR_MINUS) begin
							phase_n = PHASE_NEG;
						end else begin
							phase_n = PHASE_DONE;
						end
					end else begin
						phase_n = PHASE_DONE;
					end
				end
			end
		end

		pos_n = (pos_q == POS_MAX) ? pos_q : pos_q + 16'd1;

		frame_sum.hdr_ok    = hv_n && (pos_n >= KEY_START);
		frame_sum.key_class = class_n;
		frame_sum.key_count = count_n;
		frame_sum.src_addr  = src_n;
		frame_sum.dst_addr  = dst_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q    <= '0;
			hv_q     <= 1'b1;
			src_q    <= '0;
			dst_q    <= '0;
			shift_q  <= '0;
			count_q  <= '0;
			closed_q <= 1'b0;
			class_q  <= CLASS_NONE;
			phase_q  <= PHASE_START;
		end else if (take) begin
			if (frame_end) begin
				pos_q    <= '0;
				hv_q     <= 1'b1;
				src_q    <= '0;
				dst_q    <= '0;
				shift_q  <= '0;
				count_q  <= '0;
				closed_q <= 1'b0;
				class_q  <= CLASS_NONE;
				phase_q  <= PHASE_START;
			end else begin
				pos_q    <= pos_n;
				hv_q     <= hv_n;
				src_q    <= src_n;
				dst_q    <= dst_n;
				shift_q  <= shift_n;
				count_q  <= count_n;
				closed_q <= closed_n;
				class_q  <= class_n;
				phase_q  <= phase_n;
			end
		end
	end

endmodule : kvf_frame_track
`default_nettype wire

[rtl/kvf_resp_calc.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kvf_resp_calc
// Three-stage pipeline from the frame summary to the response lengths,
// IPv4 header checksum and verdict, with stall back-pressure.
// ----------------------------------------------------------------------------
module kvf_resp_calc
	import kvf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        sum_valid,
	input  wire frame_sum_t  frame_sum,
	output logic             sum_stall,
	input  wire logic [13:0] value_len_key_zero,
	input  wire logic [13:0] value_len_key_one,
	input  wire logic [15:0] max_response_len,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             verdict,
	output logic             key_choice,
	output logic [7:0]       key_length,
	output logic [15:0]      payload_len,
	output logic [15:0]      ip_total_len,
	output logic [15:0]      udp_len,
	output logic [15:0]      response_len,
	output logic [15:0]      ip_header_checksum
);

	logic adv_out, adv_s2, adv_s1;

	// stage 1: frame summary
	logic       v_s1;
	frame_sum_t sum_s1;

	// stage 2: value length chosen, payload length and address sum
	logic        v_s2;
	logic        ok_s2;
	logic        key_s2;
	logic [7:0]  count_s2;
	logic [15:0] payload_s2;
	logic [17:0] addr_sum_s2;

	logic        class_ok;
	logic        key_sel;
	logic [13:0] vlen;
	logic [2:0]  vdigits;
	logic [15:0] payload_c;
	logic [17:0] addr_sum_c;

	logic [15:0] resp_c;
	logic [15:0] tot_c;
	logic [19:0] csum_raw;
	logic [16:0] csum_f1;
	logic [16:0] csum_f2;
	logic        ok_c;

	assign adv_out   = !out_valid || !out_stall;
	assign adv_s2    = !v_s2 || adv_out;
	assign adv_s1    = !v_s1 || adv_s2;
	assign sum_stall = !adv_s1;

	always_comb begin
		class_ok = (sum_s1.key_class == CLASS_ZERO) || (sum_s1.key_class == CLASS_ONE);
		key_sel  = (sum_s1.key_class == CLASS_ONE);
		if (sum_s1.key_class == CLASS_ZERO) begin
			vlen = value_len_key_zero;
		end else if (sum_s1.key_class == CLASS_ONE) begin
			vlen = value_len_key_one;
		end else begin
			vlen = '0;
		end
		if (vlen < 14'd10) begin
			vdigits = 3'd1;
		end else if (vlen < 14'd100) begin
			vdigits = 3'd2;
		end else if (vlen < 14'd1000) begin
			vdigits = 3'd3;
		end else if (vlen < 14'd10000) begin
			vdigits = 3'd4;
		end else begin
			vdigits = 3'd5;
		end
		payload_c = PAYLOAD_BASE + {13'd0, vdigits} + {8'd0, sum_s1.key_count} + {2'd0, vlen};
		addr_sum_c = {2'd0, sum_s1.src_addr[31:16]} + {2'd0, sum_s1.src_addr[15:0]}
			+ {2'd0, sum_s1.dst_addr[31:16]} + {2'd0, sum_s1.dst_addr[15:0]};
	end

	always_comb begin
		resp_c   = RESP_BASE + payload_s2;
		tot_c    = IP_TOTAL_BASE + payload_s2;
		ok_c     = ok_s2 && (resp_c <= max_response_len);
		csum_raw = HDR_FIXED_SUM + {4'd0, tot_c} + {2'd0, addr_sum_s2};
		// end-around carry, twice
		csum_f1  = {1'b0, csum_raw[15:0]} + {13'd0, csum_raw[19:16]};
		csum_f2  = {1'b0, csum_f1[15:0]} + {16'd0, csum_f1[16]};
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1      <= 1'b0;
			v_s2      <= 1'b0;
			out_valid <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= sum_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_out) out_valid <= v_s2;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1 && sum_valid) begin
			sum_s1 <= frame_sum;
		end
		if (adv_s2 && v_s1) begin
			ok_s2       <= sum_s1.hdr_ok && class_ok;
			key_s2      <= key_sel;
			count_s2    <= sum_s1.key_count;
			payload_s2  <= payload_c;
			addr_sum_s2 <= addr_sum_c;
		end
		if (adv_out && v_s2) begin
			// a dropped request reports all fields as zero
			verdict            <= ok_c;
			key_choice         <= ok_c & key_s2;
			key_length         <= ok_c ? count_s2 : 8'd0;
			payload_len        <= ok_c ? payload_s2 : 16'd0;
			ip_total_len       <= ok_c ? tot_c : 16'd0;
			udp_len            <= ok_c ? UDP_BASE + payload_s2 : 16'd0;
			response_len       <= ok_c ? resp_c : 16'd0;
			ip_header_checksum <= ok_c ? ~csum_f2[15:0] : 16'd0;
		end
	end

endmodule : kvf_resp_calc
`default_nettype wire

[rtl/kv_udp_get_request_filter_core.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// kv_udp_get_request_filter_core
// Filters UDP key-value get requests and computes the response lengths.
// ----------------------------------------------------------------------------
// one request byte accepted per cycle while in_stall is low; each frame's
// verdict passes stage 1, stage 2 and the output register; one per frame
// the result side holds up to three pending verdicts before stalling input
// reset clears frame state and loads the default configuration
// ----------------------------------------------------------------------------
module kv_udp_get_request_filter_core
	import kvf_pkg::*;
(
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        in_valid,
	output logic             in_stall,
	input  wire logic [7:0]  data_byte,
	input  wire logic        frame_end,
	input  wire logic        cfg_valid,
	output logic             cfg_ready,
	input  wire logic [7:0]  cfg_index,
	input  wire logic [15:0] cfg_data,
	output logic             out_valid,
	input  wire logic        out_stall,
	output logic             verdict,
	output logic             key_choice,
	output logic [7:0]       key_length,
	output logic [15:0]      payload_len,
	output logic [15:0]      ip_total_len,
	output logic [15:0]      udp_len,
	output logic [15:0]      response_len,
	output logic [15:0]      ip_header_checksum
);

	logic [15:0] service_port_q;
	logic [13:0] value_len_zero_q;
	logic [13:0] value_len_one_q;
	logic [15:0] max_resp_len_q;

	logic       take;
	logic       sum_stall;
	frame_sum_t frame_sum;

	assign cfg_ready = 1'b1;
	assign in_stall  = sum_stall;
	assign take      = in_valid && !sum_stall;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			service_port_q   <= SERVICE_PORT_RST;
			value_len_zero_q <= VALUE_LEN_ZERO_RST;
			value_len_one_q  <= VALUE_LEN_ONE_RST;
			max_resp_len_q   <= MAX_RESP_LEN_RST;
		end else if (cfg_valid && cfg_ready) begin
			case (cfg_index)
				REG_SERVICE_PORT:   service_port_q   <= cfg_data;
				REG_VALUE_LEN_ZERO: value_len_zero_q <= cfg_data[13:0];
				REG_VALUE_LEN_ONE:  value_len_one_q  <= cfg_data[13:0];
				REG_MAX_RESP_LEN:   max_resp_len_q   <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	kvf_frame_track u_track (
		.clk          (clk),
		.arst_n       (arst_n),
		.take         (take),
		.data_byte    (data_byte),
		.frame_end    (frame_end),
		.service_port (service_port_q),
		.frame_sum    (frame_sum)
	);

	kvf_resp_calc u_calc (
		.clk                (clk),
		.arst_n             (arst_n),
		.sum_valid          (take && frame_end),
		.frame_sum          (frame_sum),
		.sum_stall          (sum_stall),
		.value_len_key_zero (value_len_zero_q),
		.value_len_key_one  (value_len_one_q),
		.max_response_len   (max_resp_len_q),
		.out_valid          (out_valid),
		.out_stall          (out_stall),
		.verdict            (verdict),
		.key_choice         (key_choice),
		.key_length         (key_length),
		.payload_len        (payload_len),
		.ip_total_len       (ip_total_len),
		.udp_len            (udp_len),
		.response_len       (response_len),
		.ip_header_checksum (ip_header_checksum)
	);

endmodule : kv_udp_get_request_filter_core
`default_nettype wire
